// ===== rtl/glr_pkg.sv =====
// Shared widths, register indexes and control types for the grid line rasterizer.
`default_nettype none

package glr_pkg;

    // Coordinate and register widths.
    localparam int CW     = 14;
    localparam int RW     = 13;
    localparam int SPAN_W = 6;
    localparam int ERR_W  = SPAN_W + 2;

    // Longest major-axis span that is stepped, and the grid size limit.
    localparam int MAX_SPAN = 63;
    localparam int MAP_DIM  = 4096;
    localparam logic [RW-1:0] MAP_DIM_R = RW'(MAP_DIM);

    // Stream and configuration port widths.
    localparam int IN_TDATA_W  = 4 * CW;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_IDX_W   = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MAP_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_COLS = 2'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic swap;
        logic order;
        logic step;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic last_cell;
    } t_status;

    // Magnitude of a signed difference.
    function automatic logic [CW:0] abs_diff(input logic signed [CW:0] v);
        abs_diff = v[CW] ? (CW+1)'(-v) : v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/glr_ctrl.sv =====
// Controller state machine that sequences setup and cell stepping for one segment.
`default_nettype none

module glr_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_tvalid,
    output logic                 o_s_tready,
    input  glr_pkg::t_status     i_status,
    output glr_pkg::t_cmd        o_cmd
);
    import glr_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SWAP  = 2'd1;
    localparam logic [1:0] ST_ORDER = 2'd2;
    localparam logic [1:0] ST_RUN   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_s_tready = (r_state == ST_IDLE);

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SWAP;
                end
            end
            ST_SWAP: begin
                o_cmd.swap = 1'b1;
                n_state    = ST_ORDER;
            end
            ST_ORDER: begin
                o_cmd.order = 1'b1;
                n_state     = ST_RUN;
            end
            ST_RUN: begin
                if (i_status.out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_status.last_cell) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/glr_dpath.sv =====
// Datapath: endpoint registers, Bresenham stepping, map bounds check and output register.
`default_nettype none

module glr_dpath (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  glr_pkg::t_cmd                            i_cmd,
    output glr_pkg::t_status                         o_status,
    input  wire logic [glr_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    input  wire logic                                i_cfg_valid,
    input  wire logic [glr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [glr_pkg::RW-1:0]              i_cfg_data,
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    output logic [glr_pkg::OUT_TDATA_W-1:0]          o_m_tdata,
    output logic                                     o_m_tlast,
    output logic                                     o_m_tuser
);
    import glr_pkg::*;

    // Configuration registers.
    logic [RW-1:0] r_map_rows;
    logic [RW-1:0] r_map_cols;
    logic [RW-1:0] rows_eff;
    logic [RW-1:0] cols_eff;

    // Endpoints, major axis in a, minor axis in b.
    logic signed [CW-1:0] r_a0, r_b0, r_a1, r_b1;
    logic                 r_steep;

    // Stepping state.
    logic signed [CW-1:0]    r_x, r_y;
    logic [SPAN_W-1:0]       r_dx, r_dy, r_cnt;
    logic signed [ERR_W-1:0] r_err;
    logic                    r_up;
    logic                    r_too_long;

    // Output register.
    logic                 r_m_valid;
    logic signed [CW-1:0] r_out_row, r_out_col;
    logic                 r_out_in_map, r_out_last, r_out_too_long;

    // Swap step: pick the major axis.
    logic signed [CW:0] da, db;
    logic               steep;

    // Order step: orient along the major axis.
    logic signed [CW:0] d_maj, d_min;
    logic               flip;
    logic [CW:0]        dx_full, dy_full;
    logic               up;

    // Step: current cell and error update.
    logic signed [CW-1:0]    cur_row, cur_col;
    logic                    in_map;
    logic signed [ERR_W-1:0] err_dec;

    assign rows_eff = (r_map_rows > MAP_DIM_R) ? MAP_DIM_R : r_map_rows;
    assign cols_eff = (r_map_cols > MAP_DIM_R) ? MAP_DIM_R : r_map_cols;

    assign da    = (CW+1)'(r_a1) - (CW+1)'(r_a0);
    assign db    = (CW+1)'(r_b1) - (CW+1)'(r_b0);
    assign steep = abs_diff(db) > abs_diff(da);

    assign d_maj   = (CW+1)'(r_a1) - (CW+1)'(r_a0);
    assign d_min   = (CW+1)'(r_b1) - (CW+1)'(r_b0);
    assign flip    = d_maj[CW];
    assign dx_full = abs_diff(d_maj);
    assign dy_full = abs_diff(d_min);
    assign up      = flip ? d_min[CW] : (!d_min[CW] && (d_min != '0));

    assign cur_row = r_steep ? r_y : r_x;
    assign cur_col = r_steep ? r_x : r_y;
    assign in_map  = !cur_row[CW-1] && (cur_row[RW-1:0] < rows_eff)
                  && !cur_col[CW-1] && (cur_col[RW-1:0] < cols_eff);
    assign err_dec = r_err - ERR_W'(r_dy);

    assign o_status.out_free  = !r_m_valid || i_m_tready;
    assign o_status.last_cell = r_too_long || (r_cnt == r_dx);

    // Configuration writes; indexes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_rows <= MAP_DIM_R;
            r_map_cols <= MAP_DIM_R;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MAP_ROWS: r_map_rows <= i_cfg_data;
                REG_MAP_COLS: r_map_cols <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Endpoint capture and axis swap.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a0 <= i_s_tdata[CW-1:0];
            r_b0 <= i_s_tdata[2*CW-1:CW];
            r_a1 <= i_s_tdata[3*CW-1:2*CW];
            r_b1 <= i_s_tdata[4*CW-1:3*CW];
        end else if (i_cmd.swap) begin
            r_steep <= steep;
            if (steep) begin
                r_a0 <= r_b0;
                r_b0 <= r_a0;
                r_a1 <= r_b1;
                r_b1 <= r_a1;
            end
        end
    end

    // Stepping registers: set up from the ordered endpoints, then advance one cell.
    always_ff @(posedge i_clk) begin
        if (i_cmd.order) begin
            r_x        <= flip ? r_a1 : r_a0;
            r_y        <= flip ? r_b1 : r_b0;
            r_dx       <= dx_full[SPAN_W-1:0];
            r_dy       <= dy_full[SPAN_W-1:0];
            r_err      <= ERR_W'(dx_full[SPAN_W-1:1]);
            r_up       <= up;
            r_cnt      <= '0;
            r_too_long <= dx_full > (CW+1)'(MAX_SPAN);
        end else if (i_cmd.step) begin
            r_x   <= r_x + CW'(1);
            r_cnt <= r_cnt + SPAN_W'(1);
            if (err_dec[ERR_W-1]) begin
                r_y   <= r_up ? (r_y + CW'(1)) : (r_y - CW'(1));
                r_err <= err_dec + ERR_W'(r_dx);
            end else begin
                r_err <= err_dec;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            if (r_too_long) begin
                r_out_row      <= '0;
                r_out_col      <= '0;
                r_out_in_map   <= 1'b0;
                r_out_last     <= 1'b1;
                r_out_too_long <= 1'b1;
            end else begin
                r_out_row      <= cur_row;
                r_out_col      <= cur_col;
                r_out_in_map   <= in_map;
                r_out_last     <= (r_cnt == r_dx);
                r_out_too_long <= 1'b0;
            end
        end
    end

    // Output valid: set on a new cell, cleared once the transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {(OUT_TDATA_W - 2*CW - 1)'(0), r_out_in_map, r_out_col, r_out_row};
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_too_long;

endmodule

`default_nettype wire

// ===== rtl/grid_line_rasterizer.sv =====
// After the input transfer the controller runs the swap and order setup steps, then the single
// stepping unit emits one cell per cycle while output back-pressure does not stall it, up to the
// end of the major-axis span; an over-long segment yields a single cell flagged too_long.
// Output back-pressure stalls stepping; the output register lets the next input be taken
// while the final cell still waits.
// Reset (synchronous, active low) idles the controller, empties the output and sets both
// map dimensions to 4096.
`default_nettype none

module grid_line_rasterizer (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Input segment: start_row[13:0], start_col[27:14], end_row[41:28], end_col[55:42].
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    input  wire logic [glr_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // Configuration write: index 0 is map_rows, index 1 is map_cols.
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [glr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [glr_pkg::RW-1:0]            i_cfg_data,
    // Output cell: cell_row[13:0], cell_col[27:14], in_map[28], zero fill above.
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic [glr_pkg::OUT_TDATA_W-1:0]        o_m_tdata,
    output logic                                   o_m_tlast,
    // Output flags: too_long[0].
    output logic                                   o_m_tuser
);
    import glr_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Configuration writes are taken in any cycle.
    assign o_cfg_ready = 1'b1;

    glr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    glr_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

`default_nettype wire
